### hdl/smm_pkg.sv
`default_nettype none

package smm_pkg;

  // matrix dimension and derived sizes
  localparam int N      = 4;
  localparam int ELEMS  = N * N;
  localparam int IDX_W  = (N > 1) ? $clog2(N) : 1;
  localparam int ADDR_W = (ELEMS > 1) ? $clog2(ELEMS) : 1;

  // fixed field widths of the channels
  localparam int OPC_W  = 2;
  localparam int POS_W  = 3;
  localparam int DATA_W = 32;

  typedef enum logic [OPC_W-1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_COMPUTE = 2'd2
  } opcode_t;

  // microprogram steps
  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_READ   = 3'd1,
    ST_DRAIN0 = 3'd2,
    ST_DRAIN1 = 3'd3,
    ST_EMIT   = 3'd4,
    ST_NEXT   = 3'd5
  } step_t;

  // branch conditions
  typedef enum logic [2:0] {
    C_ALWAYS   = 3'd0,
    C_START    = 3'd1,
    C_K_LAST   = 3'd2,
    C_OUT_BUSY = 3'd3,
    C_DONE     = 3'd4
  } cond_t;

  typedef struct packed {
    logic  take_in;
    logic  clr_acc;
    logic  rd;
    logic  emit;
    cond_t cond;
    step_t jmp_t;
    step_t jmp_f;
  } uword_t;

  // control store: one word per step
  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = '{take_in: 1'b1, clr_acc: 1'b1, rd: 1'b0, emit: 1'b0,
          cond: C_START, jmp_t: ST_READ, jmp_f: ST_IDLE};
    case (s)
      ST_IDLE: begin
        w = '{take_in: 1'b1, clr_acc: 1'b1, rd: 1'b0, emit: 1'b0,
              cond: C_START, jmp_t: ST_READ, jmp_f: ST_IDLE};
      end
      ST_READ: begin
        w = '{take_in: 1'b0, clr_acc: 1'b0, rd: 1'b1, emit: 1'b0,
              cond: C_K_LAST, jmp_t: ST_DRAIN0, jmp_f: ST_READ};
      end
      ST_DRAIN0: begin
        w = '{take_in: 1'b0, clr_acc: 1'b0, rd: 1'b0, emit: 1'b0,
              cond: C_ALWAYS, jmp_t: ST_DRAIN1, jmp_f: ST_DRAIN1};
      end
      ST_DRAIN1: begin
        w = '{take_in: 1'b0, clr_acc: 1'b0, rd: 1'b0, emit: 1'b0,
              cond: C_ALWAYS, jmp_t: ST_EMIT, jmp_f: ST_EMIT};
      end
      ST_EMIT: begin
        w = '{take_in: 1'b0, clr_acc: 1'b0, rd: 1'b0, emit: 1'b1,
              cond: C_OUT_BUSY, jmp_t: ST_EMIT, jmp_f: ST_NEXT};
      end
      ST_NEXT: begin
        w = '{take_in: 1'b0, clr_acc: 1'b0, rd: 1'b0, emit: 1'b0,
              cond: C_DONE, jmp_t: ST_IDLE, jmp_f: ST_READ};
      end
      default: begin
        w = '{take_in: 1'b0, clr_acc: 1'b1, rd: 1'b0, emit: 1'b0,
              cond: C_ALWAYS, jmp_t: ST_IDLE, jmp_f: ST_IDLE};
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### hdl/smm_ifs.sv
`default_nettype none

interface smm_in_if;
  logic                       valid;
  logic                       ready;
  logic [smm_pkg::OPC_W-1:0]  opcode;
  logic [smm_pkg::POS_W-1:0]  row;
  logic [smm_pkg::POS_W-1:0]  col;
  logic signed [smm_pkg::DATA_W-1:0] value;

  modport source (output valid, output opcode, output row, output col, output value,
                  input ready);
  modport sink   (input valid, input opcode, input row, input col, input value,
                  output ready);
endinterface

interface smm_out_if;
  logic                       valid;
  logic                       ready;
  logic [smm_pkg::POS_W-1:0]  out_row;
  logic [smm_pkg::POS_W-1:0]  out_col;
  logic signed [smm_pkg::DATA_W-1:0] product;
  logic                       last;

  modport source (output valid, output out_row, output out_col, output product,
                  output last, input ready);
  modport sink   (input valid, input out_row, input out_col, input product,
                  input last, output ready);
endinterface

`default_nettype wire

### hdl/square_matrix_multiply.sv
// load transfers are accepted only while the sequencer is idle, where ready is high
// compute: each product element runs N reads through the shared multiplier, two pipeline
//   drain steps, emit and a branch step, walking the product matrix in row-major order
// the first result is registered at the first emit; output stalls hold the sequencer in emit
// the A and B memories have one read port each and there is one multiplier: one term per read
// reset: synchronous active-low, clears sequencer, counters and valid flags, not the matrices
`default_nettype none

module square_matrix_multiply (
  input  wire         clk,
  input  wire         rst_n,
  smm_in_if.sink      in_ch,
  smm_out_if.source   out_ch
);

  localparam int N      = smm_pkg::N;
  localparam int IDX_W  = smm_pkg::IDX_W;
  localparam int ADDR_W = smm_pkg::ADDR_W;
  localparam int POS_W  = smm_pkg::POS_W;
  localparam int DATA_W = smm_pkg::DATA_W;

  // sequencer
  smm_pkg::step_t  pc_r, pc_nxt;
  smm_pkg::uword_t uw;
  logic            cond_hit;

  // loop counters: k walks the dot product, r/c walk the product matrix
  logic [IDX_W-1:0] k_r, r_r, c_r;
  logic             k_last, c_last, r_last;

  // operand memories, one write port and one registered read port each
  logic [DATA_W-1:0] mem_a [smm_pkg::ELEMS];
  logic [DATA_W-1:0] mem_b [smm_pkg::ELEMS];
  logic [DATA_W-1:0] a_q_r, b_q_r;
  logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
  logic              in_fire, ld_in_range, wr_a, wr_b;

  // multiply-accumulate pipeline
  logic              rd_v_r, mul_v_r;
  logic [DATA_W-1:0] prod_r, acc_r;

  // output register
  logic              out_valid_r;
  logic [POS_W-1:0]  out_row_r, out_col_r;
  logic [DATA_W-1:0] out_prod_r;
  logic              out_last_r;
  logic              out_busy, emit_fire;

  assign uw = smm_pkg::ucode(pc_r);

  assign in_ch.ready = uw.take_in;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign k_last   = (k_r == IDX_W'(N - 1));
  assign c_last   = (c_r == IDX_W'(N - 1));
  assign r_last   = (r_r == IDX_W'(N - 1));
  assign out_busy = out_valid_r && !out_ch.ready;

  // condition select for the microword branch
  always_comb begin
    case (uw.cond)
      smm_pkg::C_ALWAYS:   cond_hit = 1'b1;
      smm_pkg::C_START:    cond_hit = in_fire && (in_ch.opcode == smm_pkg::OP_COMPUTE);
      smm_pkg::C_K_LAST:   cond_hit = k_last;
      smm_pkg::C_OUT_BUSY: cond_hit = out_busy;
      smm_pkg::C_DONE:     cond_hit = (r_r == '0) && (c_r == '0);
      default:             cond_hit = 1'b0;
    endcase
    pc_nxt = cond_hit ? uw.jmp_t : uw.jmp_f;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= smm_pkg::ST_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // emit only when the output register is free or being drained
  assign emit_fire = uw.emit && !out_busy;

  // load path: out-of-range indexes and the unused opcode are dropped
  assign ld_in_range = ({1'b0, in_ch.row} < (POS_W + 1)'(N)) &&
                       ({1'b0, in_ch.col} < (POS_W + 1)'(N));
  assign wr_a    = in_fire && ld_in_range && (in_ch.opcode == smm_pkg::OP_LOAD_A);
  assign wr_b    = in_fire && ld_in_range && (in_ch.opcode == smm_pkg::OP_LOAD_B);
  assign wr_addr = ADDR_W'(int'(in_ch.row) * N + int'(in_ch.col));

  // A is read along row r, B down column c
  assign rd_addr_a = ADDR_W'(int'(r_r) * N + int'(k_r));
  assign rd_addr_b = ADDR_W'(int'(k_r) * N + int'(c_r));

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[wr_addr] <= in_ch.value;
    end
    a_q_r <= mem_a[rd_addr_a];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[wr_addr] <= in_ch.value;
    end
    b_q_r <= mem_b[rd_addr_b];
  end

  // counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
      r_r <= '0;
      c_r <= '0;
    end else begin
      if (uw.rd) begin
        k_r <= k_last ? '0 : k_r + 1'b1;
      end
      if (emit_fire) begin
        // row-major walk, wraps to zero after the last element
        if (c_last) begin
          c_r <= '0;
          r_r <= r_last ? '0 : r_r + 1'b1;
        end else begin
          c_r <= c_r + 1'b1;
        end
      end
    end
  end

  // read -> multiply -> accumulate, valid flags track the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r  <= 1'b0;
      mul_v_r <= 1'b0;
    end else begin
      rd_v_r  <= uw.rd;
      mul_v_r <= rd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= DATA_W'(a_q_r * b_q_r);   // low word only, wraps mod 2^32
    if (uw.clr_acc || emit_fire) begin
      acc_r <= '0;
    end else if (mul_v_r) begin
      acc_r <= acc_r + prod_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_row_r  <= POS_W'(r_r);
      out_col_r  <= POS_W'(c_r);
      out_prod_r <= acc_r;
      out_last_r <= r_last && c_last;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.out_row = out_row_r;
  assign out_ch.out_col = out_col_r;
  assign out_ch.product = out_prod_r;
  assign out_ch.last    = out_last_r;

`ifndef SYNTHESIS
  ap_pipe_advance: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |=> mul_v_r)
    else $error("read valid did not reach multiply stage");

  ap_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == smm_pkg::ST_EMIT) |-> (!rd_v_r && !mul_v_r))
    else $error("emit while accumulation still in flight");

  ap_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == smm_pkg::ST_IDLE) |-> (k_r == '0 && r_r == '0 && c_r == '0))
    else $error("counters not at zero in idle");

  ap_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |->
      (out_row_r == POS_W'(N - 1) && out_col_r == POS_W'(N - 1)))
    else $error("last flag on a non-final element");

  ap_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire |=> out_valid_r)
    else $error("emitted element not held in output register");
`endif

endmodule

`default_nettype wire
